// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/sfa_pkg.sv -----
// Package for the secp256k1 field arithmetic unit: constants, opcodes, states.
// Depends on nothing.
package sfa_pkg;
  localparam logic [255:0] PRIME = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                                    64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2F};
  localparam logic [255:0] EXP_PM2 = {64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                                      64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2D};
  localparam logic [32:0] FOLD_C = 33'h1000003D1;
  // Low part of FOLD_C; the 2^32 part is applied as a one-word shift.
  localparam logic [9:0]  FOLD_LO = 10'd977;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_INV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIX,
    ST_MSTART,
    ST_PROD,
    ST_FOLD,
    ST_FOLD2,
    ST_WRAP,
    ST_MFIN,
    ST_ISTEP,
    ST_DONE
  } state_t;
endpackage

// ----- hw/rtl/secp256k1_field_alu.sv -----
// Secp256k1 prime field unit: add, subtract, multiply and inverse modulo p,
// built from one 32x32 multiplier, one 257-bit adder and a sequencer; depends
// on sfa_pkg and assert_macros.svh. Add and subtract pass through ST_ADD and
// ST_FIX to ST_DONE, which loads the output register. A multiply scans the 64
// word products column by column, folds the upper half word by word, then
// finishes in ST_FOLD2, ST_WRAP and ST_MFIN. Inverse runs 256 squarings and 249
// multiplications. The result waits in an output register; a new transaction
// may be accepted meanwhile, but it cannot finish until the earlier result has
// been taken.
`include "assert_macros.svh"
module secp256k1_field_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_a_limb0,
  input  logic [63:0] in_a_limb1,
  input  logic [63:0] in_a_limb2,
  input  logic [63:0] in_a_limb3,
  input  logic [63:0] in_b_limb0,
  input  logic [63:0] in_b_limb1,
  input  logic [63:0] in_b_limb2,
  input  logic [63:0] in_b_limb3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_r_limb0,
  output logic [63:0] out_r_limb1,
  output logic [63:0] out_r_limb2,
  output logic [63:0] out_r_limb3
);

  sfa_pkg::state_t state_r, state_nxt;
  sfa_pkg::op_t    op_r;
  logic [255:0] a_r, b_r, res_r, base_r;
  logic [255:0] ma_r, mb_r;          // multiply operands
  logic [511:0] prod_r;              // full product, 16 words
  logic [256:0] acc_r;               // fold accumulator with carry
  logic [71:0]  cacc_r;              // column accumulator and fold carry
  logic [31:0]  hprev_r;             // previous upper-half word during the fold
  logic [33:0]  top_r;               // part of the fold above 2^256
  logic [3:0]   col_r;               // product column
  logic [2:0]   row_r;               // word of ma_r within the column
  logic [2:0]   fidx_r;              // fold word index
  logic [7:0]   bit_r;
  logic         sq_r;                // inverse: squaring phase
  logic         out_valid_r;
  logic [255:0] out_r;

  // Column scan limits: column k covers ma words max(0,k-7) to min(k,7).
  logic [3:0] row_hi, col_inc;
  logic [2:0] row_lo_nxt, mcol;
  logic       col_last;
  assign row_hi     = (col_r > 4'd7) ? 4'd7 : col_r;
  assign col_inc    = col_r + 4'd1;
  assign row_lo_nxt = (col_inc > 4'd7) ? 3'(col_inc - 4'd7) : 3'd0;
  assign mcol       = 3'(col_r - {1'b0, row_r});
  assign col_last   = ({1'b0, row_r} == row_hi);

  // Shared multiplier
  logic [31:0] mx, my;
  logic [63:0] mp;

  always_comb begin
    mx = ma_r[32*row_r +: 32];
    my = mb_r[32*mcol +: 32];
    if (state_r == sfa_pkg::ST_FOLD) begin
      mx = prod_r[256 + 32*fidx_r +: 32];
      my = {22'd0, sfa_pkg::FOLD_LO};
    end
  end
  assign mp = mx * my;

  // Product column sum, and one word of low half + high half * (2^32 + 977).
  logic [71:0] csum, fsum;
  assign csum = cacc_r + {8'd0, mp};
  assign fsum = csum + {40'd0, prod_r[32*fidx_r +: 32]} + {40'd0, hprev_r};

  logic [66:0] top_c;
  assign top_c = {1'b0, top_r, 32'd0} + ({33'd0, top_r} * {57'd0, sfa_pkg::FOLD_LO});

  // Shared wide adder
  logic [256:0] add_x, add_y, add_s;
  logic         add_ci;
  logic [255:0] sub_d;
  logic         sub_bw, ge_p;
  assign add_s = add_x + add_y + {256'd0, add_ci};
  assign {sub_bw, sub_d} = {1'b0, acc_r[255:0]} - {1'b0, sfa_pkg::PRIME};
  assign ge_p = !sub_bw;

  always_comb begin
    add_x  = 257'd0;
    add_y  = 257'd0;
    add_ci = 1'b0;
    unique case (state_r)
      sfa_pkg::ST_ADD: begin
        add_x = {1'b0, a_r};
        if (op_r == sfa_pkg::OP_ADD) begin
          add_y = {1'b0, b_r};
        end else begin
          add_y  = {1'b0, ~b_r};
          add_ci = 1'b1;
        end
      end
      sfa_pkg::ST_FIX: begin
        add_x = {1'b0, acc_r[255:0]};
        add_y = {1'b0, sfa_pkg::PRIME};
      end
      sfa_pkg::ST_FOLD2: begin
        add_x = {1'b0, acc_r[255:0]};
        add_y = {190'd0, top_c};
      end
      sfa_pkg::ST_WRAP: begin
        // A wrap past 2^256 is worth 2^32 + 977.
        add_x = {1'b0, acc_r[255:0]};
        add_y = acc_r[256] ? {224'd0, sfa_pkg::FOLD_C} : 257'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfa_pkg::ST_IDLE:
        if (in_valid && in_ready) begin
          state_nxt = (in_opcode == sfa_pkg::OP_ADD || in_opcode == sfa_pkg::OP_SUB) ?
                      sfa_pkg::ST_ADD : sfa_pkg::ST_MSTART;
        end
      sfa_pkg::ST_ADD:    state_nxt = sfa_pkg::ST_FIX;
      sfa_pkg::ST_FIX:    state_nxt = sfa_pkg::ST_DONE;
      sfa_pkg::ST_MSTART: state_nxt = sfa_pkg::ST_PROD;
      sfa_pkg::ST_PROD:   if (col_r == 4'd14) state_nxt = sfa_pkg::ST_FOLD;
      sfa_pkg::ST_FOLD:   if (fidx_r == 3'd7) state_nxt = sfa_pkg::ST_FOLD2;
      sfa_pkg::ST_FOLD2:  state_nxt = sfa_pkg::ST_WRAP;
      sfa_pkg::ST_WRAP:   state_nxt = sfa_pkg::ST_MFIN;
      sfa_pkg::ST_MFIN:
        state_nxt = (op_r == sfa_pkg::OP_INV) ? sfa_pkg::ST_ISTEP : sfa_pkg::ST_DONE;
      sfa_pkg::ST_ISTEP:
        state_nxt = (sq_r && bit_r == 8'd255) ? sfa_pkg::ST_DONE : sfa_pkg::ST_MSTART;
      sfa_pkg::ST_DONE:   if (!out_valid_r) state_nxt = sfa_pkg::ST_IDLE;
      default:            state_nxt = sfa_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == sfa_pkg::ST_IDLE);

  logic [255:0] mres;
  assign mres = ge_p ? sub_d : acc_r[255:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      else if (state_r == sfa_pkg::ST_DONE && !out_valid_r) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      sfa_pkg::ST_IDLE: if (in_valid) begin
        op_r   <= sfa_pkg::op_t'(in_opcode);
        a_r    <= {in_a_limb3, in_a_limb2, in_a_limb1, in_a_limb0};
        b_r    <= {in_b_limb3, in_b_limb2, in_b_limb1, in_b_limb0};
        base_r <= {in_a_limb3, in_a_limb2, in_a_limb1, in_a_limb0};
        res_r  <= 256'd1;
        bit_r  <= 8'd0;
        sq_r   <= !sfa_pkg::EXP_PM2[0];
      end
      sfa_pkg::ST_ADD: acc_r <= add_s;
      sfa_pkg::ST_FIX: begin
        // Add corrects on carry or at least p; subtract adds p on borrow.
        if (op_r == sfa_pkg::OP_ADD) begin
          if (acc_r[256] || ge_p) acc_r <= {1'b0, sub_d};
        end else if (!acc_r[256]) begin
          acc_r <= {1'b0, add_s[255:0]};
        end
      end
      sfa_pkg::ST_MSTART: begin
        col_r   <= 4'd0;
        row_r   <= 3'd0;
        fidx_r  <= 3'd0;
        cacc_r  <= 72'd0;
        hprev_r <= 32'd0;
        acc_r   <= 257'd0;
        if (op_r == sfa_pkg::OP_MUL) begin
          ma_r <= a_r; mb_r <= b_r;
        end else if (sq_r) begin
          ma_r <= base_r; mb_r <= base_r;
        end else begin
          ma_r <= res_r; mb_r <= base_r;
        end
      end
      sfa_pkg::ST_PROD: begin
        if (col_last) begin
          // The last column also carries out the top word of the product.
          if (col_r == 4'd14) begin
            prod_r[511:448] <= csum[63:0];
            cacc_r          <= 72'd0;
          end else begin
            prod_r[32*col_r +: 32] <= csum[31:0];
            cacc_r                 <= {32'd0, csum[71:32]};
          end
          col_r <= col_inc;
          row_r <= row_lo_nxt;
        end else begin
          cacc_r <= csum;
          row_r  <= row_r + 3'd1;
        end
      end
      sfa_pkg::ST_FOLD: begin
        acc_r[32*fidx_r +: 32] <= fsum[31:0];
        cacc_r  <= {32'd0, fsum[71:32]};
        hprev_r <= mx;
        fidx_r  <= fidx_r + 3'd1;
        if (fidx_r == 3'd7) top_r <= fsum[65:32] + {2'd0, mx};
      end
      sfa_pkg::ST_FOLD2: acc_r <= add_s;
      sfa_pkg::ST_WRAP:  acc_r <= add_s;
      sfa_pkg::ST_MFIN: begin
        acc_r <= {1'b0, mres};
        if (sq_r) base_r <= mres;
        else res_r <= mres;
      end
      sfa_pkg::ST_ISTEP: begin
        if (!sq_r) sq_r <= 1'b1;
        else begin
          bit_r <= bit_r + 8'd1;
          sq_r  <= !sfa_pkg::EXP_PM2[bit_r + 8'd1];
        end
        if (state_nxt == sfa_pkg::ST_DONE) acc_r <= {1'b0, res_r};
      end
      sfa_pkg::ST_DONE: if (!out_valid_r) out_r <= acc_r[255:0];
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_r_limb0 = out_r[63:0];
  assign out_r_limb1 = out_r[127:64];
  assign out_r_limb2 = out_r[191:128];
  assign out_r_limb3 = out_r[255:192];

  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_r_limb0))
  `ASSERT_NEXT(a_load, clk, rst_n, state_r == sfa_pkg::ST_DONE && !out_valid_r, out_valid_r)
  `ASSERT_IMPLY(a_wrap, clk, rst_n, state_r == sfa_pkg::ST_MFIN, !acc_r[256])

endmodule
